FILE: sv/fcte_pkg.sv
// Package for the flow cache with timeout export block.
// Holds table sizing constants, protocol codes and the shared item types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcte_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Command queue between the front and back parts; depth is a power of two.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam int         FIN_BIT    = 0;

    localparam int         CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TMO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UDP_TMO    = 1'b1;
    localparam logic [31:0] ACTIVE_TMO_RESET = 32'd60000;
    localparam logic [31:0] UDP_TMO_RESET    = 32'd10000;

    typedef struct packed {
        logic        flush;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
        logic [7:0]  tos;
        logic [7:0]  tflags;
        logic [15:0] byte_len;
        logic [31:0] time_ms;
    } t_cmd;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
        logic [7:0]  tos;
        logic [7:0]  tflags;
        logic [31:0] packets;
        logic [31:0] octets;
        logic [31:0] first_ms;
        logic [31:0] last_ms;
    } t_flow;

    typedef struct packed {
        logic [31:0] active_ms;
        logic [31:0] udp_ms;
    } t_timeouts;

endpackage

`default_nettype wire

FILE: sv/fcte_front.sv
// Front part: accepts input items, drops unsupported protocols and
// normalizes ports and flags. Depends on fcte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcte_front import fcte_pkg::*; (
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_func,
    input  wire logic [31:0] i_src_ip,
    input  wire logic [31:0] i_dst_ip,
    input  wire logic [15:0] i_sport,
    input  wire logic [15:0] i_dport,
    input  wire logic [7:0]  i_protocol,
    input  wire logic [7:0]  i_tos,
    input  wire logic [7:0]  i_tflags,
    input  wire logic [15:0] i_byte_len,
    input  wire logic [31:0] i_time_ms,
    input  wire logic        i_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic is_icmp;
    logic is_tcp;
    logic keep;

    assign is_icmp    = (i_protocol == PROTO_ICMP);
    assign is_tcp     = (i_protocol == PROTO_TCP);
    assign keep       = i_func || is_icmp || is_tcp || (i_protocol == PROTO_UDP);
    assign o_in_ready = !i_full;
    // Items of other protocols are taken and dropped here.
    assign o_push     = i_in_valid && !i_full && keep;

    always_comb begin
        o_cmd.flush    = i_func;
        o_cmd.src_ip   = i_src_ip;
        o_cmd.dst_ip   = i_dst_ip;
        o_cmd.sport    = is_icmp ? 16'd0 : i_sport;
        o_cmd.dport    = is_icmp ? 16'd0 : i_dport;
        o_cmd.protocol = i_protocol;
        o_cmd.tos      = i_tos;
        o_cmd.tflags   = is_tcp ? i_tflags : 8'd0;
        o_cmd.byte_len = i_byte_len;
        o_cmd.time_ms  = i_time_ms;
    end

endmodule

`default_nettype wire

FILE: sv/fcte_fifo.sv
// Short command queue between the front and back parts.
// Depends on fcte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcte_fifo import fcte_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

`default_nettype wire

FILE: sv/fcte_back.sv
// Back part: flow table memory, entry scan sequencer and export register.
// Depends on fcte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcte_back import fcte_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_timeouts i_tmo,
    input  wire logic i_empty,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_flow     o_flow,
    output logic      o_last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    t_flow              r_mem [ENTRIES];
    t_flow              r_rd;
    logic [2:0]         r_state, n_state;
    t_cmd               r_cmd;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_all, n_all;
    logic               r_then_tmo, n_then_tmo;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]   r_used, n_used;
    logic               r_hit_v, n_hit_v;
    logic [IDX_W-1:0]   r_hit_idx;
    t_flow              r_hit_ent;
    logic               r_pend_v, n_pend_v;
    t_flow              r_pend;
    logic               r_out_v, n_out_v;
    t_flow              r_out;
    logic               r_out_last;

    logic [31:0]      idle_ms;
    logic             tmo;
    logic             do_exp;
    logic             key_eq;
    logic             match;
    logic             out_free;
    logic             ev_go;
    logic             step;
    logic             scan_end;
    logic             push_mid;
    logic             push_fin;
    logic [IDX_W-1:0] free_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    t_flow            wr_ent;

    assign idle_ms  = r_cmd.time_ms - r_rd.last_ms;
    assign tmo      = ((r_rd.protocol == PROTO_TCP)
                       && ((idle_ms > i_tmo.active_ms) || r_rd.tflags[FIN_BIT]))
                   || ((r_rd.protocol == PROTO_UDP) && (idle_ms > i_tmo.udp_ms));
    assign do_exp   = r_all || tmo;
    assign key_eq   = ({r_rd.src_ip, r_rd.dst_ip, r_rd.sport, r_rd.dport,
                        r_rd.protocol, r_rd.tos}
                    == {r_cmd.src_ip, r_cmd.dst_ip, r_cmd.sport, r_cmd.dport,
                        r_cmd.protocol, r_cmd.tos});
    assign match    = (r_state == S_EV) && !do_exp && key_eq && !r_hit_v;
    assign out_free = !r_out_v || i_out_ready;
    assign ev_go    = (r_state == S_EV) && (!do_exp || !r_pend_v || out_free);
    assign step     = ev_go || ((r_state == S_RD) && !r_valid[r_idx]);
    assign scan_end = (r_idx == IDX_W'(ENTRIES - 1));
    assign push_mid = ev_go && do_exp && r_pend_v;
    assign push_fin = (r_state == S_FIN) && r_pend_v && out_free;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    // Lowest free entry.
    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) free_idx = IDX_W'(i);
        end
    end

    always_comb begin
        wr_en  = (r_state == S_INS);
        wr_idx = r_hit_v ? r_hit_idx : free_idx;
        if (r_hit_v) begin
            wr_ent         = r_hit_ent;
            wr_ent.packets = r_hit_ent.packets + 32'd1;
            wr_ent.octets  = r_hit_ent.octets + {16'd0, r_cmd.byte_len};
            wr_ent.last_ms = r_cmd.time_ms;
            wr_ent.tflags  = r_hit_ent.tflags | r_cmd.tflags;
        end else begin
            wr_ent.src_ip   = r_cmd.src_ip;
            wr_ent.dst_ip   = r_cmd.dst_ip;
            wr_ent.sport    = r_cmd.sport;
            wr_ent.dport    = r_cmd.dport;
            wr_ent.protocol = r_cmd.protocol;
            wr_ent.tos      = r_cmd.tos;
            wr_ent.tflags   = r_cmd.tflags;
            wr_ent.packets  = 32'd1;
            wr_ent.octets   = {16'd0, r_cmd.byte_len};
            wr_ent.first_ms = r_cmd.time_ms;
            wr_ent.last_ms  = r_cmd.time_ms;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_all      = r_all;
        n_then_tmo = r_then_tmo;
        n_valid    = r_valid;
        n_used     = r_used;
        n_hit_v    = r_hit_v || match;
        n_pend_v   = r_pend_v;
        n_out_v    = r_out_v && !i_out_ready;
        if (push_mid || push_fin) n_out_v = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state    = S_RD;
                    n_idx      = '0;
                    n_hit_v    = 1'b0;
                    n_all      = i_cmd.flush || (r_used == CNT_W'(ENTRIES));
                    n_then_tmo = !i_cmd.flush;
                end
            end
            S_RD: begin
                if (r_valid[r_idx]) n_state = S_EV;
            end
            S_EV: begin
                if (ev_go) begin
                    n_state = S_RD;
                    if (do_exp) begin
                        n_valid[r_idx] = 1'b0;
                        n_used         = r_used - 1'b1;
                        n_pend_v       = 1'b1;
                    end
                end
            end
            S_INS: begin
                n_state = S_FIN;
                if (!r_hit_v) begin
                    n_valid[free_idx] = 1'b1;
                    n_used            = r_used + 1'b1;
                end
            end
            S_FIN: begin
                if (!r_pend_v || out_free) begin
                    n_state  = S_IDLE;
                    n_pend_v = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (step) begin
            if (!scan_end) begin
                n_idx   = r_idx + 1'b1;
                n_state = S_RD;
            end else if (r_all && r_then_tmo) begin
                n_idx      = '0;
                n_all      = 1'b0;
                n_then_tmo = 1'b0;
                n_state    = S_RD;
            end else if (r_cmd.flush) begin
                n_state = S_FIN;
            end else begin
                n_state = S_INS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_all      <= 1'b0;
            r_then_tmo <= 1'b0;
            r_valid    <= '0;
            r_used     <= '0;
            r_hit_v    <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_all      <= n_all;
            r_then_tmo <= n_then_tmo;
            r_valid    <= n_valid;
            r_used     <= n_used;
            r_hit_v    <= n_hit_v;
            r_pend_v   <= n_pend_v;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_idx];
        if (wr_en) r_mem[wr_idx] <= wr_ent;
        if (o_pop) r_cmd <= i_cmd;
        if (match) begin
            r_hit_idx <= r_idx;
            r_hit_ent <= r_rd;
        end
        if (ev_go && do_exp) r_pend <= r_rd;
        if (push_mid || push_fin) begin
            r_out      <= r_pend;
            r_out_last <= push_fin;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_flow      = r_out;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

FILE: sv/flow_cache_with_timeout_export_core.sv
// Flow cache with timeout export, top level. An item starts, scans every table entry and reads each
// valid one (two full passes when a packet finds the table full), then writes back and closes
// (a flush only closes); the scan of the flow memory sets the pace, and a stalled result
// holds the scan. Items are worked one at a time.
// The first result leaves when the second export is found or when the scan ends.
// Reset (synchronous, active low) clears the table, the queue and both timeouts to defaults.
`timescale 1ns / 1ps
`default_nettype none

module flow_cache_with_timeout_export_core import fcte_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_func,
    input  wire logic [31:0]          i_src_ip,
    input  wire logic [31:0]          i_dst_ip,
    input  wire logic [15:0]          i_sport,
    input  wire logic [15:0]          i_dport,
    input  wire logic [7:0]           i_protocol,
    input  wire logic [7:0]           i_tos,
    input  wire logic [7:0]           i_tflags,
    input  wire logic [15:0]          i_byte_len,
    input  wire logic [31:0]          i_time_ms,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [31:0]               o_flow_src_ip,
    output logic [31:0]               o_flow_dst_ip,
    output logic [15:0]               o_flow_sport,
    output logic [15:0]               o_flow_dport,
    output logic [7:0]                o_flow_protocol,
    output logic [7:0]                o_flow_tos,
    output logic [7:0]                o_flow_tflags,
    output logic [31:0]               o_flow_packets,
    output logic [31:0]               o_flow_octets,
    output logic [31:0]               o_flow_first_ms,
    output logic [31:0]               o_flow_last_ms,
    output logic                      o_last_of_run
);

    // Timeout registers take every write; user must issue them only while idle (not enforced).
    t_timeouts r_tmo;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tmo.active_ms <= ACTIVE_TMO_RESET;
            r_tmo.udp_ms    <= UDP_TMO_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_TMO: r_tmo.active_ms <= i_cfg_data;
                CFG_UDP_TMO:    r_tmo.udp_ms    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front classifies each item and queues the ones that need work.
    logic  push;
    logic  full;
    logic  pop;
    logic  empty;
    t_cmd  fr_cmd;
    t_cmd  q_cmd;
    t_flow flow;

    fcte_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_src_ip   (i_src_ip),
        .i_dst_ip   (i_dst_ip),
        .i_sport    (i_sport),
        .i_dport    (i_dport),
        .i_protocol (i_protocol),
        .i_tos      (i_tos),
        .i_tflags   (i_tflags),
        .i_byte_len (i_byte_len),
        .i_time_ms  (i_time_ms),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (fr_cmd)
    );

    fcte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (fr_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (q_cmd)
    );

    // The back part scans the table, exports flows and writes the packet back.
    fcte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tmo       (r_tmo),
        .i_empty     (empty),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_flow      (flow),
        .o_last      (o_last_of_run)
    );

    assign o_flow_src_ip   = flow.src_ip;
    assign o_flow_dst_ip   = flow.dst_ip;
    assign o_flow_sport    = flow.sport;
    assign o_flow_dport    = flow.dport;
    assign o_flow_protocol = flow.protocol;
    assign o_flow_tos      = flow.tos;
    assign o_flow_tflags   = flow.tflags;
    assign o_flow_packets  = flow.packets;
    assign o_flow_octets   = flow.octets;
    assign o_flow_first_ms = flow.first_ms;
    assign o_flow_last_ms  = flow.last_ms;

endmodule

`default_nettype wire

FILE: sv/fcte_checker.sv
// Port-level checks for the flow cache top level, bound to it below.
// Depends on flow_cache_with_timeout_export_core.
`timescale 1ns / 1ps
`default_nettype none

module fcte_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_flow_packets,
    input wire logic        o_last_of_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_flow_packets) && $stable(o_last_of_run))
        else $error("result item changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item right after reset");

    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(i_in_valid && o_in_ready))
        else $error("input ready fell without an accepted item");

endmodule

bind flow_cache_with_timeout_export_core fcte_checker u_fcte_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_flow_packets (o_flow_packets),
    .o_last_of_run  (o_last_of_run)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for flow_cache_with_timeout_export_core.
// Feeds packet and flush items, predicts the exported flows in a local flow-table
// model and checks every exported flow; depends on fcte_pkg and the core.
`timescale 1ns / 1ps

module testbench;
    import fcte_pkg::*;

    typedef struct {
        t_flow flow;
        logic  last;
    } t_export;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        i_func = 1'b0;
    logic [31:0] i_src_ip = '0;
    logic [31:0] i_dst_ip = '0;
    logic [15:0] i_sport = '0;
    logic [15:0] i_dport = '0;
    logic [7:0]  i_protocol = '0;
    logic [7:0]  i_tos = '0;
    logic [7:0]  i_tflags = '0;
    logic [15:0] i_byte_len = '0;
    logic [31:0] i_time_ms = '0;
    logic        i_out_ready = 1'b0;
    logic        o_cfg_ready, o_in_ready, o_out_valid, o_last_of_run;
    logic [31:0] o_flow_src_ip, o_flow_dst_ip, o_flow_packets, o_flow_octets;
    logic [31:0] o_flow_first_ms, o_flow_last_ms;
    logic [15:0] o_flow_sport, o_flow_dport;
    logic [7:0]  o_flow_protocol, o_flow_tos, o_flow_tflags;

    flow_cache_with_timeout_export_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Items waiting to be offered, and flows the table is expected to export.
    t_cmd    packet_q[$];
    t_export export_q[$];
    int      errors = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;
    bit      hold_start = 0;
    bit      hold_done = 0;
    int      hold_left = 0;
    longint  cycles = 0;

    // Local copy of the flow table and the timeouts.
    bit          tbl_valid[ENTRIES];
    t_flow       tbl_flow[ENTRIES];
    int          tbl_used = 0;
    logic [31:0] active_ms = ACTIVE_TMO_RESET;
    logic [31:0] udp_ms = UDP_TMO_RESET;

    // Key pool so that flows repeat, the table fills and timeouts trigger.
    localparam int KEYS = 48;
    logic [31:0] key_src[KEYS], key_dst[KEYS];
    logic [15:0] key_sport[KEYS], key_dport[KEYS];
    logic [7:0]  key_proto[KEYS], key_tos[KEYS];
    logic [31:0] clock_ms;

    function automatic void export_entry(int e);
        t_export x;
        x.flow = tbl_flow[e];
        x.last = 1'b0;
        export_q.push_back(x);
        tbl_valid[e] = 0;
        if (tbl_used > 0) tbl_used--;
    endfunction

    function automatic int export_table();
        int n = 0;
        for (int e = 0; e < ENTRIES; e++)
            if (tbl_valid[e]) begin
                export_entry(e);
                n++;
            end
        return n;
    endfunction

    // Accounts one accepted item to the table and queues the flows it exports.
    function automatic void account_item(t_cmd c);
        int n = 0;
        int hit = -1;
        logic [31:0] idle;
        logic [15:0] sp, dp;
        logic [7:0] fl;
        if (c.flush) begin
            n = export_table();
        end else begin
            if (c.protocol != PROTO_TCP && c.protocol != PROTO_UDP &&
                c.protocol != PROTO_ICMP)
                return;
            sp = (c.protocol == PROTO_ICMP) ? 16'd0 : c.sport;
            dp = (c.protocol == PROTO_ICMP) ? 16'd0 : c.dport;
            fl = (c.protocol == PROTO_TCP) ? c.tflags : 8'd0;
            if (tbl_used >= ENTRIES) n += export_table();
            for (int e = 0; e < ENTRIES; e++) begin
                if (!tbl_valid[e]) continue;
                idle = c.time_ms - tbl_flow[e].last_ms;
                if ((tbl_flow[e].protocol == PROTO_TCP &&
                     (idle > active_ms || tbl_flow[e].tflags[FIN_BIT])) ||
                    (tbl_flow[e].protocol == PROTO_UDP && idle > udp_ms)) begin
                    export_entry(e);
                    n++;
                end
            end
            for (int e = 0; e < ENTRIES; e++)
                if (tbl_valid[e] && tbl_flow[e].src_ip == c.src_ip &&
                    tbl_flow[e].dst_ip == c.dst_ip && tbl_flow[e].sport == sp &&
                    tbl_flow[e].dport == dp && tbl_flow[e].protocol == c.protocol &&
                    tbl_flow[e].tos == c.tos) begin
                    hit = e;
                    break;
                end
            if (hit >= 0) begin
                tbl_flow[hit].packets += 32'd1;
                tbl_flow[hit].octets += {16'd0, c.byte_len};
                tbl_flow[hit].last_ms = c.time_ms;
                tbl_flow[hit].tflags |= fl;
            end else begin
                for (int e = 0; e < ENTRIES; e++)
                    if (!tbl_valid[e]) begin
                        tbl_valid[e] = 1;
                        tbl_flow[e] = '{c.src_ip, c.dst_ip, sp, dp, c.protocol, c.tos,
                                        fl, 32'd1, {16'd0, c.byte_len}, c.time_ms,
                                        c.time_ms};
                        tbl_used++;
                        break;
                    end
            end
        end
        if (n > 0) export_q[export_q.size() - 1].last = 1'b1;
    endfunction

    // Driver: offers the oldest pending item, holding it until it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                account_item('{i_func, i_src_ip, i_dst_ip, i_sport, i_dport,
                               i_protocol, i_tos, i_tflags, i_byte_len, i_time_ms});
            if (i_in_valid && !o_in_ready) begin
                i_in_valid <= 1'b1;
            end else if (packet_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                t_cmd c;
                c = packet_q.pop_front();
                i_in_valid <= 1'b1;
                i_func     <= c.flush;
                i_src_ip   <= c.src_ip;
                i_dst_ip   <= c.dst_ip;
                i_sport    <= c.sport;
                i_dport    <= c.dport;
                i_protocol <= c.protocol;
                i_tos      <= c.tos;
                i_tflags   <= c.tflags;
                i_byte_len <= c.byte_len;
                i_time_ms  <= c.time_ms;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver ready, with one long hold-off so that the core backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_start && !hold_done) begin
            i_out_ready <= 1'b0;
            hold_left <= 3000;
            hold_done <= 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Monitor: every exported flow is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (export_q.size() == 0) begin
                $display("%0t: unexpected flow, expected none, actual src %h dst %h",
                         $time, o_flow_src_ip, o_flow_dst_ip);
                errors++;
            end else begin
                t_export x;
                x = export_q.pop_front();
                check_field("src_ip", x.flow.src_ip, o_flow_src_ip);
                check_field("dst_ip", x.flow.dst_ip, o_flow_dst_ip);
                check_field("sport", 32'(x.flow.sport), 32'(o_flow_sport));
                check_field("dport", 32'(x.flow.dport), 32'(o_flow_dport));
                check_field("protocol", 32'(x.flow.protocol), 32'(o_flow_protocol));
                check_field("tos", 32'(x.flow.tos), 32'(o_flow_tos));
                check_field("tflags", 32'(x.flow.tflags), 32'(o_flow_tflags));
                check_field("packets", x.flow.packets, o_flow_packets);
                check_field("octets", x.flow.octets, o_flow_octets);
                check_field("first_ms", x.flow.first_ms, o_flow_first_ms);
                check_field("last_ms", x.flow.last_ms, o_flow_last_ms);
                check_field("last_of_run", 32'(x.last), 32'(o_last_of_run));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1000000) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ACTIVE_TMO) active_ms = data;
        else udp_ms = data;
    endtask

    // Waits until everything offered has been accepted and exported, then lets
    // the core finish any scan started by an item that exports nothing.
    task automatic drain();
        do @(posedge i_clk);
        while (packet_q.size() != 0 || i_in_valid || export_q.size() != 0);
        repeat (300) @(posedge i_clk);
        while (export_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic push_item(logic fl, logic [31:0] s, logic [31:0] d, logic [31:0] sp,
                             logic [31:0] dp, logic [31:0] pr, logic [31:0] tos,
                             logic [31:0] flags, logic [31:0] len, logic [31:0] t);
        t_cmd c;
        c.flush    = fl;
        c.src_ip   = s;
        c.dst_ip   = d;
        c.sport    = sp[15:0];
        c.dport    = dp[15:0];
        c.protocol = pr[7:0];
        c.tos      = tos[7:0];
        c.tflags   = flags[7:0];
        c.byte_len = len[15:0];
        c.time_ms  = t;
        packet_q.push_back(c);
    endtask

    // Mostly well-formed traffic over the key pool, some noise and flushes.
    task automatic push_traffic(int count);
        int k, r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            clock_ms += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200000)
                                                    : $urandom_range(0, 40);
            if (r < 4) begin
                push_item(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
            end else if (r < 10) begin
                push_item(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
            end else begin
                k = $urandom_range(0, KEYS - 1);
                push_item(1'b0, key_src[k], key_dst[k], 32'(key_sport[k]),
                          32'(key_dport[k]), 32'(key_proto[k]), 32'(key_tos[k]),
                          ($urandom_range(0, 11) == 0) ? 32'($urandom & 32'hFF)
                                                       : 32'($urandom & 32'hFE),
                          $urandom, clock_ms);
            end
        end
    endtask

    initial begin
        int pick;
        for (int k = 0; k < KEYS; k++) begin
            pick = $urandom_range(0, 2);
            key_src[k]   = $urandom;
            key_dst[k]   = $urandom;
            key_sport[k] = 16'($urandom);
            key_dport[k] = 16'($urandom);
            key_proto[k] = (pick == 0) ? PROTO_TCP : (pick == 1) ? PROTO_UDP : PROTO_ICMP;
            key_tos[k]   = 8'($urandom);
        end
        clock_ms = $urandom;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset timeouts.
        push_item(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0);                     // flush of an empty table
        push_item(1'b0, 0, 0, 0, 0, 32'(PROTO_TCP), 0, 0, 0, 0);        // all-zero TCP packet
        push_item(1'b0, '1, '1, '1, '1, 32'(PROTO_TCP), '1, 32'hFE, '1, '1); // all-ones TCP
        push_item(1'b0, '1, '1, '1, '1, 32'(PROTO_TCP), '1, 32'h10, '1, 32'd5); // timestamp wraps
        push_item(1'b0, 1, 2, 3, 4, 32'(PROTO_UDP), 32'h20, 32'hFF, 100, 32'd10); // UDP flags
        push_item(1'b0, 5, 6, 32'hABCD, 32'h1234, 32'(PROTO_ICMP), 0, 32'hFF, 64,
                  32'd20);                                              // ports zeroed
        push_item(1'b0, 7, 8, 9, 10, 0, 0, 0, 40, 32'd30);              // other protocol ignored
        push_item(1'b0, 7, 8, 9, 10, 32'hFF, 0, 0, 40, 32'd30);
        push_item(1'b0, 11, 12, 80, 443, 32'(PROTO_TCP), 0, 32'h01, 60, 32'd40); // FIN seen
        push_item(1'b0, 13, 14, 80, 443, 32'(PROTO_TCP), 0, 32'h02, 60, 32'd50); // FIN export
        push_item(1'b0, 1, 2, 3, 4, 32'(PROTO_UDP), 32'h20, 0, 100, 32'd20011); // UDP idle
        push_item(1'b0, 13, 14, 80, 443, 32'(PROTO_TCP), 0, 0, 60, 32'd90000); // TCP idle
        push_item(1'b1, '1, '1, '1, '1, '1, '1, '1, '1, '1);             // flush ignores fields
        drain();

        // Zero timeouts: every TCP and UDP flow goes on the next packet with a later time.
        write_reg(CFG_ACTIVE_TMO, 32'd0);
        write_reg(CFG_UDP_TMO, 32'd0);
        push_traffic(35);
        drain();

        // Maximum timeouts, so the table fills and overflows; sender mostly idle.
        write_reg(CFG_ACTIVE_TMO, 32'hFFFF_FFFF);
        write_reg(CFG_UDP_TMO, 32'hFFFF_FFFF);
        idle_pct = 83;
        push_traffic(45);
        drain();

        // Short timeouts with the receiver stalling.
        write_reg(CFG_ACTIVE_TMO, 32'd100);
        write_reg(CFG_UDP_TMO, 32'd50);
        idle_pct = 0;
        stall_pct = 83;
        push_traffic(40);
        drain();

        // Random timeouts, light idling on both sides.
        write_reg(CFG_ACTIVE_TMO, $urandom_range(0, 5000));
        write_reg(CFG_UDP_TMO, $urandom);
        idle_pct = 7;
        stall_pct = 7;
        push_traffic(25);
        drain();

        // Long receiver hold-off while flushes of a partly filled table keep coming.
        write_reg(CFG_ACTIVE_TMO, 32'hFFFF_FFFF);
        write_reg(CFG_UDP_TMO, 32'hFFFF_FFFF);
        idle_pct = 0;
        stall_pct = 0;
        for (int n = 0; n < 10; n++) begin
            push_traffic(3);
            push_item(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        end
        hold_start = 1;
        push_traffic(20);
        drain();

        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

FILE: flow_cache_with_timeout_export_core.f
sv/fcte_pkg.sv
sv/fcte_front.sv
sv/fcte_fifo.sv
sv/fcte_back.sv
sv/flow_cache_with_timeout_export_core.sv
sv/fcte_checker.sv
tb/sv/testbench.sv
